[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ARC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ARC_ASSERT_NEXT(label, ante, cons) \
  `ARC_ASSERT(label, (ante) |=> (cons))

`endif

[rtl/arc_pkg.sv]
// ---------------------------------------------------------------------------
// arc_pkg
// Types, sizes and codes of the ARP resolver with cache.
// ---------------------------------------------------------------------------
package arc_pkg;

  localparam int CACHE_ENTRIES   = 16;
  localparam int REQUEST_ENTRIES = 8;
  localparam int QUEUE_DEPTH     = 16;

  localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RIDX_W = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CCNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int RCNT_W = $clog2(REQUEST_ENTRIES + 1);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = (CCNT_W > RCNT_W) ?
                          ((CCNT_W > QCNT_W) ? CCNT_W : QCNT_W) :
                          ((RCNT_W > QCNT_W) ? RCNT_W : QCNT_W);

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_IPV4 = 2'd0;
  localparam logic [1:0] KIND_ARP  = 2'd1;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_REPLY   = 3'd3;
  localparam logic [2:0] ACT_DELIVER = 3'd4;
  localparam logic [2:0] ACT_DROP    = 3'd5;

  typedef enum logic [1:0] {
    REG_OWN_MAC    = 2'd0,
    REG_OWN_IP     = 2'd1,
    REG_REQ_HOLD   = 2'd2,
    REG_CACHE_LIFE = 2'd3
  } arc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND_CACHE,
    ST_SEND_REQ,
    ST_SEND_MISS,
    ST_SEND_ARQ,
    ST_RX,
    ST_LEARN,
    ST_LEARN_WR,
    ST_FLUSH,
    ST_REPLY,
    ST_TICK_REQ,
    ST_TICK_CACHE,
    ST_DONE
  } arc_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] next_hop_ip;
    logic [15:0] packet_tag;
    logic [47:0] frame_dst_mac;
    logic [1:0]  frame_kind;
    logic        parse_ok;
    logic        arp_is_request;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
  } arc_cmd_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dst_mac;
    logic [31:0] target_ip;
    logic [15:0] out_tag;
    logic        last;
  } arc_res_t;

  // Sequencer to output stage: push a word, or close the command.
  typedef struct packed {
    logic     push;
    logic     finish;
    arc_res_t res;
  } arc_emit_t;

endpackage

[rtl/arc_out_stage.sv]
// ---------------------------------------------------------------------------
// arc_out_stage
// Holds one result word back so the final word of a command carries last.
// ---------------------------------------------------------------------------
module arc_out_stage import arc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  arc_emit_t emit_i,
  output logic      res_valid_o,
  output arc_res_t  res_o
);

  logic     held_v_q, held_v_d;
  arc_res_t held_q, held_d;
  logic     out_v_q, out_v_d;
  arc_res_t out_q, out_d;

  always_comb begin
    held_v_d = held_v_q;
    held_d   = held_q;
    out_v_d  = 1'b0;
    out_d    = held_q;
    if (emit_i.push) begin
      // release the previous word, hold the new one
      out_v_d      = held_v_q;
      out_d.last   = 1'b0;
      held_v_d     = 1'b1;
      held_d       = emit_i.res;
    end else if (emit_i.finish) begin
      out_v_d = 1'b1;
      if (!held_v_q) begin
        out_d        = '0;
        out_d.action = ACT_NONE;
      end
      out_d.last = 1'b1;
      held_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

[rtl/arp_resolver_with_cache.sv]
// ---------------------------------------------------------------------------
// arp_resolver_with_cache
// ARP resolver: 16-entry cache, 8 pending requests, 16-word datagram queue.
// ---------------------------------------------------------------------------
// Pulse start while busy is low to hand in one command word. The block then
// holds busy high while a small sequencer walks the tables one entry per
// cycle; the cache and request scans share a single compare/add unit. Results
// come out on res_o, one word per res_valid_o pulse, and cannot be stalled:
// capture each word in the cycle it is shown. Every command yields at least
// one word and its final word has last set; busy drops at the edge that shows
// it. The table scans set how long a command runs: a send scans the cache up
// to the hit, and on a miss the request table too; an ARP receive scans the
// cache, then the queue; a tick scans the request table, then the cache; an
// IPv4 or dropped receive and an unknown command scan nothing. No clearing
// pass is needed after reset; valid bits clear at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_resolver_with_cache import arc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  arc_cmd_t    item_i,
  output logic        res_valid_o,
  output arc_res_t    res_o
);

  // configuration
  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q, hold_q, life_q;

  // tables: valid bits reset, payload kept in plain flops
  logic [CACHE_ENTRIES-1:0]   cval_q;
  logic [31:0]                cip_q  [CACHE_ENTRIES];
  logic [47:0]                cmac_q [CACHE_ENTRIES];
  logic [31:0]                cage_q [CACHE_ENTRIES];
  logic [REQUEST_ENTRIES-1:0] rval_q;
  logic [31:0]                rip_q  [REQUEST_ENTRIES];
  logic [31:0]                rage_q [REQUEST_ENTRIES];
  logic [31:0]                qip_q  [QUEUE_DEPTH];
  logic [15:0]                qtag_q [QUEUE_DEPTH];
  logic [QCNT_W-1:0]          qcnt_q, qcnt_d;

  // sequencer
  arc_state_e        state_q, state_d;
  arc_cmd_t          item_q, item_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [QCNT_W-1:0] n_q, n_d;
  logic              hit_q, hit_d, free_v_q, free_v_d;
  logic [IDX_W-1:0]  hidx_q, hidx_d, free_idx_q, free_idx_d, old_idx_q, old_idx_d;
  logic [31:0]       old_age_q, old_age_d;
  arc_emit_t         emit;

  // table write controls
  logic              cv_we, cv_wval, ce_we, ca_we;
  logic [CIDX_W-1:0] c_widx;
  logic [31:0]       ca_wval;
  logic              rv_we, rv_wval, re_we, ra_we;
  logic [RIDX_W-1:0] r_widx;
  logic [31:0]       ra_wval;
  logic              q_we;
  logic [QIDX_W-1:0] q_widx;
  logic [31:0]       q_wip;
  logic [15:0]       q_wtag;

  // read port at the scan pointer
  logic [CIDX_W-1:0] cidx;
  logic [RIDX_W-1:0] ridx;
  logic [QIDX_W-1:0] qidx;
  logic              c_v, r_v;
  logic [31:0]       c_ip, c_age, r_ip, r_age, q_ip;
  logic [47:0]       c_mac;
  logic [15:0]       q_tag;

  assign cidx  = idx_q[CIDX_W-1:0];
  assign ridx  = idx_q[RIDX_W-1:0];
  assign qidx  = idx_q[QIDX_W-1:0];
  assign c_v   = cval_q[cidx];
  assign c_ip  = cip_q[cidx];
  assign c_mac = cmac_q[cidx];
  assign c_age = cage_q[cidx];
  assign r_v   = rval_q[ridx];
  assign r_ip  = rip_q[ridx];
  assign r_age = rage_q[ridx];
  assign q_ip  = qip_q[qidx];
  assign q_tag = qtag_q[qidx];

  // shared unit: one IP compare, two age compares, one saturating add
  logic        in_req_scan, in_cache_scan, scan_first, scan_last;
  logic        sc_v, sc_match;
  logic [31:0] sc_ip, sc_key, sc_age, sc_limit;
  logic [32:0] sum;
  logic [31:0] sat_age;
  logic        send_hit, rx_good, q_end, reply_due, q_full;

  assign in_req_scan   = (state_q == ST_SEND_REQ) || (state_q == ST_TICK_REQ);
  assign in_cache_scan = !in_req_scan;
  assign sc_v     = in_req_scan ? r_v : c_v;
  assign sc_ip    = in_req_scan ? r_ip : c_ip;
  assign sc_age   = in_req_scan ? r_age : c_age;
  assign sc_limit = in_req_scan ? hold_q : life_q;
  assign sc_key   = (state_q == ST_LEARN) ? item_q.arp_sender_ip : item_q.next_hop_ip;
  assign sc_match = sc_v && (sc_ip == sc_key);
  assign scan_first = (idx_q == '0);
  assign scan_last  = in_req_scan ? (idx_q == IDX_W'(REQUEST_ENTRIES - 1))
                                  : (idx_q == IDX_W'(CACHE_ENTRIES - 1));
  assign sum     = {1'b0, sc_age} + {17'b0, item_q.elapsed_ms};
  assign sat_age = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign send_hit  = (state_q == ST_SEND_CACHE) && sc_match;
  assign rx_good   = ((item_q.frame_dst_mac == own_mac_q) ||
                      (item_q.frame_dst_mac == MAC_BCAST)) && item_q.parse_ok;
  assign q_end     = (IDX_W'(QCNT_W'(idx_q)) == idx_q) &&
                     (QCNT_W'(idx_q) == qcnt_q);
  assign reply_due = item_q.arp_is_request && (item_q.arp_target_ip == own_ip_q);
  assign q_full    = (qcnt_q == QCNT_W'(QUEUE_DEPTH));
  assign busy      = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (item_i.cmd)
            CMD_SEND: state_d = ST_SEND_CACHE;
            CMD_RECV: state_d = ST_RX;
            CMD_TICK: state_d = ST_TICK_REQ;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_SEND_CACHE: begin
        if (send_hit)       state_d = ST_DONE;
        else if (scan_last) state_d = ST_SEND_REQ;
      end
      ST_SEND_REQ:   if (scan_last) state_d = ST_SEND_MISS;
      ST_SEND_MISS:  state_d = ST_SEND_ARQ;
      ST_SEND_ARQ:   state_d = ST_DONE;
      ST_RX: begin
        if (rx_good && item_q.frame_kind == KIND_ARP) state_d = ST_LEARN;
        else                                          state_d = ST_DONE;
      end
      ST_LEARN:      if (scan_last) state_d = ST_LEARN_WR;
      ST_LEARN_WR:   state_d = ST_FLUSH;
      ST_FLUSH:      if (q_end) state_d = ST_REPLY;
      ST_REPLY:      state_d = ST_DONE;
      ST_TICK_REQ:   if (scan_last) state_d = ST_TICK_CACHE;
      ST_TICK_CACHE: if (scan_last) state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d     = item_q;
    idx_d      = idx_q;
    n_d        = n_q;
    qcnt_d     = qcnt_q;
    hit_d      = hit_q;
    hidx_d     = hidx_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    old_idx_d  = old_idx_q;
    old_age_d  = old_age_q;
    emit       = '0;
    cv_we = 1'b0; cv_wval = 1'b0; ce_we = 1'b0; ca_we = 1'b0;
    c_widx = cidx; ca_wval = '0;
    rv_we = 1'b0; rv_wval = 1'b0; re_we = 1'b0; ra_we = 1'b0;
    r_widx = ridx; ra_wval = '0;
    q_we = 1'b0; q_widx = qcnt_q[QIDX_W-1:0];
    q_wip = item_q.next_hop_ip; q_wtag = item_q.packet_tag;

    // match, first free and oldest trackers for the send request scan and the learn scan
    if (state_q == ST_SEND_REQ || state_q == ST_LEARN) begin
      hit_d    = (!scan_first && hit_q) || sc_match;
      hidx_d   = ((scan_first || !hit_q) && sc_match) ? idx_q : hidx_q;
      free_v_d = (!scan_first && free_v_q) || !sc_v;
      free_idx_d = ((scan_first || !free_v_q) && !sc_v) ? idx_q : free_idx_q;
      if (scan_first || sc_age > old_age_q) begin
        old_idx_d = idx_q;
        old_age_d = sc_age;
      end
    end

    unique case (state_q) inside
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          idx_d  = '0;
        end
      end
      ST_SEND_CACHE, ST_SEND_REQ, ST_LEARN: begin
        idx_d = scan_last ? '0 : idx_q + 1'b1;
        if (send_hit) begin
          emit.push            = 1'b1;
          emit.res.action      = ACT_SEND;
          emit.res.dst_mac     = c_mac;
          emit.res.out_tag     = item_q.packet_tag;
        end
      end
      ST_SEND_MISS: begin
        if (q_full) begin
          emit.push        = 1'b1;
          emit.res.action  = ACT_DROP;
          emit.res.out_tag = item_q.packet_tag;
        end else begin
          q_we   = 1'b1;
          qcnt_d = qcnt_q + 1'b1;
        end
      end
      ST_SEND_ARQ: begin
        if (!hit_q) begin
          emit.push          = 1'b1;
          emit.res.action    = ACT_REQUEST;
          emit.res.dst_mac   = MAC_BCAST;
          emit.res.target_ip = item_q.next_hop_ip;
          rv_we   = 1'b1;
          rv_wval = 1'b1;
          re_we   = 1'b1;
          ra_we   = 1'b1;
          r_widx  = free_v_q ? free_idx_q[RIDX_W-1:0] : old_idx_q[RIDX_W-1:0];
        end
      end
      ST_RX: begin
        idx_d = '0;
        if (rx_good && item_q.frame_kind == KIND_IPV4) begin
          emit.push        = 1'b1;
          emit.res.action  = ACT_DELIVER;
          emit.res.out_tag = item_q.packet_tag;
        end
      end
      ST_LEARN_WR: begin
        // known IP keeps its slot, else first free, else oldest
        cv_we   = 1'b1;
        cv_wval = 1'b1;
        ce_we   = 1'b1;
        ca_we   = 1'b1;
        c_widx  = hit_q ? hidx_q[CIDX_W-1:0] :
                  free_v_q ? free_idx_q[CIDX_W-1:0] : old_idx_q[CIDX_W-1:0];
        idx_d   = '0;
        n_d     = '0;
      end
      ST_FLUSH: begin
        if (q_end) begin
          qcnt_d = n_q;
        end else begin
          idx_d = idx_q + 1'b1;
          if (q_ip == item_q.arp_sender_ip) begin
            emit.push        = 1'b1;
            emit.res.action  = ACT_SEND;
            emit.res.dst_mac = item_q.arp_sender_mac;
            emit.res.out_tag = q_tag;
          end else begin
            // compact the survivors toward the head
            q_we   = 1'b1;
            q_widx = n_q[QIDX_W-1:0];
            q_wip  = q_ip;
            q_wtag = q_tag;
            n_d    = n_q + 1'b1;
          end
        end
      end
      ST_REPLY: begin
        if (reply_due) begin
          emit.push          = 1'b1;
          emit.res.action    = ACT_REPLY;
          emit.res.dst_mac   = item_q.arp_sender_mac;
          emit.res.target_ip = item_q.arp_sender_ip;
        end
      end
      ST_TICK_REQ, ST_TICK_CACHE: begin
        idx_d = scan_last ? '0 : idx_q + 1'b1;
        if (sc_v) begin
          ca_wval = sat_age;
          ra_wval = sat_age;
          ca_we   = in_cache_scan;
          ra_we   = in_req_scan;
          if (sat_age >= sc_limit) begin
            cv_we = in_cache_scan;
            rv_we = in_req_scan;
          end
        end
      end
      ST_DONE: emit.finish = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      qcnt_q    <= '0;
      cval_q    <= '0;
      rval_q    <= '0;
      own_mac_q <= '0;
      own_ip_q  <= '0;
      hold_q    <= 32'd5000;
      life_q    <= 32'd30000;
    end else begin
      state_q <= state_d;
      qcnt_q  <= qcnt_d;
      if (cv_we) cval_q[c_widx] <= cv_wval;
      if (rv_we) rval_q[r_widx] <= rv_wval;
      if (cfg_we_i) begin
        unique case (arc_reg_e'(cfg_idx_i))
          REG_OWN_MAC:    own_mac_q <= cfg_data_i;
          REG_OWN_IP:     own_ip_q  <= cfg_data_i[31:0];
          REG_REQ_HOLD:   hold_q    <= cfg_data_i[31:0];
          REG_CACHE_LIFE: life_q    <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    hit_q      <= hit_d;
    hidx_q     <= hidx_d;
    free_v_q   <= free_v_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
    if (ce_we) begin
      cip_q[c_widx]  <= item_q.arp_sender_ip;
      cmac_q[c_widx] <= item_q.arp_sender_mac;
    end
    if (ca_we) cage_q[c_widx] <= ca_wval;
    if (re_we) rip_q[r_widx]  <= item_q.next_hop_ip;
    if (ra_we) rage_q[r_widx] <= ra_wval;
    if (q_we) begin
      qip_q[q_widx]  <= q_wip;
      qtag_q[q_widx] <= q_wtag;
    end
  end

  arc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // busy ends exactly when the closing word is shown
  `ARC_ASSERT(a_last_on_release, $fell(busy) |-> (res_valid_o && res_o.last))
  // an accepted command holds the block busy
  `ARC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  // queue fill never passes its depth
  `ARC_ASSERT(a_queue_bound, qcnt_q <= QCNT_W'(QUEUE_DEPTH))

endmodule
